[hw/rtl/mlfq_pkg.sv]
// ----------------------------------------------------------------------------
// mlfq_pkg: shared types and constants of the multilevel feedback queue
// Action and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package mlfq_pkg;

	localparam int DEF_SLOTS     = 64;
	localparam int DEF_LEVELS    = 5;
	localparam int DEF_WAIT_BITS = 16;
	localparam int SLOT_W        = 6;
	localparam int LEVEL_W       = 3;
	localparam int AGE_W         = 16;
	localparam int AGE_RESET     = 30;

	localparam logic [1:0] ACT_ENQUEUE = 2'd0;
	localparam logic [1:0] ACT_TICK    = 2'd1;
	localparam logic [1:0] ACT_PICK    = 2'd2;
	localparam logic [1:0] ACT_REQUEUE = 2'd3;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUT,
		S_TICK,
		S_AGE_SEL,
		S_AGE_SLOT,
		S_AGE_PUT,
		S_PICK_SEL,
		S_PICK_SLOT
	} seq_state_t;

endpackage

[hw/rtl/multilevel_feedback_queue_sched_unit.sv]
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_sched_unit: MLFQ scheduler with aging
// Keeps per-level FIFOs of task slots and per-slot level and wait counters.
// ----------------------------------------------------------------------------
// Usage: a request is issued by holding start high with action, slot, level,
// quantum_used and any_running valid; it is taken at a rising edge where busy
// is low. Exactly one result follows: status, picked_valid, picked_slot and
// picked_level are valid for the single cycle in which done is high, and the
// receiver must take them then, since it cannot stall the block.
// A duplicate or out-of-range enqueue or requeue is answered from the idle
// state; an enqueue or requeue reads the slot table and then writes the
// slot's level and queue entry. A tick reads each slot's wait counter in turn
// and writes it back one higher, unless it is saturated or is the request's
// slot while any_running is set. A pick first ages levels 1 to LEVELS-1,
// taking each queued entry there through a queue-store read, a slot-table
// read and a write, then pops the winner the same way or, if none, ends.
// A new request may be taken in the cycle in which done is high. Reset empties
// all levels, clears every slot's level, wait count and queued flag, and sets
// age_limit to 30; no clearing pass is needed because the slot table carries a
// written flag per entry. age_limit sits at APB address 0; the user must write
// it only while busy is low, since the block itself does not enforce it.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_sched_unit
	import mlfq_pkg::*;
#(
	parameter int SLOTS     = DEF_SLOTS,
	parameter int LEVELS    = DEF_LEVELS,
	parameter int WAIT_BITS = DEF_WAIT_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          action,
	input  logic [SLOT_W-1:0]   slot,
	input  logic [LEVEL_W-1:0]  level,
	input  logic                quantum_used,
	input  logic                any_running,
	output logic                done,
	output logic [1:0]          status,
	output logic                picked_valid,
	output logic [SLOT_W-1:0]   picked_slot,
	output logic [LEVEL_W-1:0]  picked_level,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int SIW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNTW = $clog2(SLOTS + 1);
	localparam int LVW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int SAW  = $clog2(LEVELS * SLOTS);
	localparam int SMW  = LVW + WAIT_BITS;
	localparam int CW   = (WAIT_BITS > AGE_W) ? WAIT_BITS : AGE_W;
	localparam int EXW  = (CNTW > SLOT_W) ? CNTW : SLOT_W;

	localparam logic [LVW-1:0]       LV_TOP   = LVW'(LEVELS - 1);
	localparam logic [WAIT_BITS-1:0] WAIT_MAX = '1;

	function automatic logic [SAW-1:0] store_addr(input logic [LVW-1:0] lv,
		input logic [SIW-1:0] p);
		return SAW'(lv) * SAW'(SLOTS) + SAW'(p);
	endfunction

	function automatic logic [SIW-1:0] ptr_next(input logic [SIW-1:0] p);
		return (p == SIW'(SLOTS - 1)) ? '0 : SIW'(p + 1'b1);
	endfunction

	// Configuration
	logic [AGE_W-1:0] age_limit_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? 32'(age_limit_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= AGE_W'(AGE_RESET);
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			age_limit_q <= pwdata[AGE_W-1:0];
		end
	end

	// State
	seq_state_t state_q, state_d;

	logic [SLOTS-1:0]  queued_q;
	logic [SLOTS-1:0]  written_q;
	logic [SIW-1:0]    head_q  [LEVELS];
	logic [SIW-1:0]    tail_q  [LEVELS];
	logic [CNTW-1:0]   count_q [LEVELS];

	logic [1:0]         act_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [LEVEL_W-1:0] lvl_in_q;
	logic               qused_q;
	logic               run_q;
	logic [CNTW-1:0]    tc_q;
	logic [LVW-1:0]     age_lvl_q;
	logic [CNTW-1:0]    remain_q;
	logic [SLOT_W-1:0]  cur_slot_q;
	logic [LVW-1:0]     pk_lvl_q;

	// Memories
	logic [SLOT_W-1:0] store_mem [LEVELS*SLOTS];
	logic [SMW-1:0]    slot_mem  [SLOTS];
	logic [SLOT_W-1:0] store_rd_q;
	logic [SMW-1:0]    slot_rd_q;
	logic              slot_rd_vld_q;

	logic              st_we;
	logic [SAW-1:0]    st_wa, st_ra;
	logic [SLOT_W-1:0] st_wd;
	logic              sm_we;
	logic [SIW-1:0]    sm_wa, sm_ra;
	logic [SMW-1:0]    sm_wd;

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_wa] <= st_wd;
		end
		store_rd_q <= store_mem[st_ra];
		if (sm_we) begin
			slot_mem[sm_wa] <= sm_wd;
		end
		slot_rd_q <= slot_mem[sm_ra];
	end

	// An entry that was never written reads as level zero and wait zero.
	logic [LVW-1:0]       rd_lvl;
	logic [WAIT_BITS-1:0] rd_wait;
	assign rd_lvl  = slot_rd_vld_q ? slot_rd_q[SMW-1:WAIT_BITS] : '0;
	assign rd_wait = slot_rd_vld_q ? slot_rd_q[WAIT_BITS-1:0] : '0;

	// Sequencer outputs
	logic               put_en, take_en;
	logic [LVW-1:0]     put_lv, take_lv;
	logic               q_set, q_clr;
	logic [SIW-1:0]     q_idx;
	logic               res_en;
	logic [1:0]         res_status;
	logic               res_pv;
	logic [SLOT_W-1:0]  res_slot;
	logic [LVW-1:0]     res_lvl;
	logic               accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		logic [LVW-1:0]  new_lvl;
		logic            promote;
		logic            found;
		logic [LVW-1:0]  first_lv;
		logic [EXW-1:0]  tick_idx;
		state_d    = state_q;
		put_en     = 1'b0;
		put_lv     = '0;
		take_en    = 1'b0;
		take_lv    = '0;
		q_set      = 1'b0;
		q_clr      = 1'b0;
		q_idx      = SIW'(cur_slot_q);
		res_en     = 1'b0;
		res_status = ST_DONE;
		res_pv     = 1'b0;
		res_slot   = '0;
		res_lvl    = '0;
		st_we      = 1'b0;
		st_wa      = '0;
		st_wd      = cur_slot_q;
		st_ra      = '0;
		sm_we      = 1'b0;
		sm_wa      = SIW'(cur_slot_q);
		sm_wd      = '0;
		sm_ra      = SIW'(slot);
		new_lvl    = '0;
		promote    = 1'b0;
		found      = 1'b0;
		first_lv   = '0;
		tick_idx   = EXW'(tc_q - 1'b1);

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (action == ACT_TICK) begin
						state_d = S_TICK;
					end else if (action == ACT_PICK) begin
						state_d = S_AGE_SEL;
					end else if (32'(slot) >= SLOTS) begin
						res_en = 1'b1;
					end else if (queued_q[SIW'(slot)]) begin
						res_en     = 1'b1;
						res_status = ST_DUP;
					end else begin
						state_d = S_PUT;
					end
				end
			end
			S_PUT: begin
				if (act_q == ACT_ENQUEUE) begin
					new_lvl = (32'(lvl_in_q) >= LEVELS) ? LV_TOP : LVW'(lvl_in_q);
				end else if (qused_q && (rd_lvl != LV_TOP)) begin
					new_lvl = LVW'(rd_lvl + 1'b1);
				end else begin
					new_lvl = rd_lvl;
				end
				sm_we  = 1'b1;
				sm_wa  = SIW'(slot_q);
				sm_wd  = {new_lvl, {WAIT_BITS{1'b0}}};
				q_set  = 1'b1;
				q_idx  = SIW'(slot_q);
				if (32'(count_q[new_lvl]) < SLOTS) begin
					put_en = 1'b1;
					put_lv = new_lvl;
					st_we  = 1'b1;
					st_wa  = store_addr(new_lvl, tail_q[new_lvl]);
					st_wd  = slot_q;
				end
				res_en  = 1'b1;
				state_d = S_IDLE;
			end
			S_TICK: begin
				// Read slot tc while writing back slot tc-1.
				sm_ra = tc_q[SIW-1:0];
				if (tc_q != '0) begin
					sm_we = 1'b1;
					sm_wa = SIW'(tick_idx);
					if ((run_q && (tick_idx == EXW'(slot_q))) || (rd_wait == WAIT_MAX)) begin
						sm_wd = {rd_lvl, rd_wait};
					end else begin
						sm_wd = {rd_lvl, WAIT_BITS'(rd_wait + 1'b1)};
					end
				end
				if (tc_q == CNTW'(SLOTS)) begin
					res_en  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_AGE_SEL: begin
				st_ra = store_addr(age_lvl_q, head_q[age_lvl_q]);
				if (remain_q != '0) begin
					state_d = S_AGE_SLOT;
				end else if (age_lvl_q == LV_TOP) begin
					state_d = S_PICK_SEL;
				end
			end
			S_AGE_SLOT: begin
				sm_ra   = SIW'(store_rd_q);
				state_d = S_AGE_PUT;
			end
			S_AGE_PUT: begin
				promote = (CW'(rd_wait) > CW'(age_limit_q));
				new_lvl = promote ? LVW'(age_lvl_q - 1'b1) : age_lvl_q;
				take_en = 1'b1;
				take_lv = age_lvl_q;
				put_en  = 1'b1;
				put_lv  = new_lvl;
				st_we   = 1'b1;
				st_wa   = store_addr(new_lvl, tail_q[new_lvl]);
				if (promote) begin
					sm_we = 1'b1;
					sm_wd = {new_lvl, {WAIT_BITS{1'b0}}};
				end
				state_d = S_AGE_SEL;
			end
			S_PICK_SEL: begin
				for (int l = LEVELS - 1; l >= 0; l--) begin
					if (count_q[l] != '0) begin
						found    = 1'b1;
						first_lv = LVW'(l);
					end
				end
				st_ra = store_addr(first_lv, head_q[first_lv]);
				if (found) begin
					state_d = S_PICK_SLOT;
				end else begin
					res_en     = 1'b1;
					res_status = ST_EMPTY;
					state_d    = S_IDLE;
				end
			end
			S_PICK_SLOT: begin
				// The popped slot's level is kept; only its wait count clears.
				sm_ra   = SIW'(store_rd_q);
				state_d = S_PUT;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// The pick's write-back shares the enqueue state, told apart by act_q.
		if (state_q == S_PUT && act_q == ACT_PICK) begin
			put_en   = 1'b0;
			st_we    = 1'b0;
			q_set    = 1'b0;
			q_clr    = 1'b1;
			q_idx    = SIW'(cur_slot_q);
			take_en  = 1'b1;
			take_lv  = pk_lvl_q;
			sm_wa    = SIW'(cur_slot_q);
			sm_wd    = {rd_lvl, {WAIT_BITS{1'b0}}};
			res_pv   = 1'b1;
			res_slot = cur_slot_q;
			res_lvl  = pk_lvl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			queued_q      <= '0;
			written_q     <= '0;
			slot_rd_vld_q <= 1'b0;
			done          <= 1'b0;
			tc_q          <= '0;
			age_lvl_q     <= '0;
			remain_q      <= '0;
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l]  <= '0;
				tail_q[l]  <= '0;
				count_q[l] <= '0;
			end
		end else begin
			state_q       <= state_d;
			slot_rd_vld_q <= written_q[sm_ra];
			done          <= res_en;
			if (sm_we) begin
				written_q[sm_wa] <= 1'b1;
			end
			if (q_set) begin
				queued_q[q_idx] <= 1'b1;
			end
			if (q_clr) begin
				queued_q[q_idx] <= 1'b0;
			end
			for (int l = 0; l < LEVELS; l++) begin
				if (put_en && put_lv == LVW'(l)) begin
					tail_q[l] <= ptr_next(tail_q[l]);
				end
				if (take_en && take_lv == LVW'(l)) begin
					head_q[l] <= ptr_next(head_q[l]);
				end
				if ((put_en && put_lv == LVW'(l)) && !(take_en && take_lv == LVW'(l))) begin
					count_q[l] <= CNTW'(count_q[l] + 1'b1);
				end else if (!(put_en && put_lv == LVW'(l)) && (take_en && take_lv == LVW'(l))) begin
					count_q[l] <= CNTW'(count_q[l] - 1'b1);
				end
			end
			if (accept && action == ACT_TICK) begin
				tc_q <= '0;
			end else if (state_q == S_TICK) begin
				tc_q <= CNTW'(tc_q + 1'b1);
			end
			if (accept && action == ACT_PICK) begin
				age_lvl_q <= LVW'(1);
				remain_q  <= count_q[1];
			end else if (state_q == S_AGE_SEL && remain_q == '0 && age_lvl_q != LV_TOP) begin
				age_lvl_q <= LVW'(age_lvl_q + 1'b1);
				remain_q  <= count_q[LVW'(age_lvl_q + 1'b1)];
			end else if (state_q == S_AGE_PUT) begin
				remain_q <= CNTW'(remain_q - 1'b1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= action;
			slot_q   <= slot;
			lvl_in_q <= level;
			qused_q  <= quantum_used;
			run_q    <= any_running;
		end
		if (state_q == S_AGE_SLOT || state_q == S_PICK_SLOT) begin
			cur_slot_q <= store_rd_q;
		end
		if (state_q == S_PICK_SEL) begin
			for (int l = LEVELS - 1; l >= 0; l--) begin
				if (count_q[l] != '0) begin
					pk_lvl_q <= LVW'(l);
				end
			end
		end
		if (res_en) begin
			status       <= res_status;
			picked_valid <= res_pv;
			picked_slot  <= res_slot;
			picked_level <= LEVEL_W'(res_lvl);
		end
	end

endmodule
